[sv/lprq_pkg.sv]
// Shared types and codes for the length-prefixed record ring queue.
// Used by lprq_front, lprq_back and the top level; no dependencies.
`default_nettype none

package lprq_pkg;

    typedef enum logic [1:0] {
        OP_OPEN = 2'd0,
        OP_DATA = 2'd1,
        OP_POP  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOPUSH   = 3'd3,
        ST_PUSHOPEN = 3'd4
    } status_t;

    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int FREE_W = 13;
    localparam int CNT_W  = 12;

    typedef struct packed {
        op_t               op;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] din;
    } cmd_t;

endpackage

`default_nettype wire

[sv/lprq_front.sv]
// Front end: accepts items, decodes the kind into an operation and holds
// them in a two-entry command queue for the back end. Depends on lprq_pkg.
`default_nettype none

module lprq_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 kind,
    input  wire logic [lprq_pkg::LEN_W-1:0] record_length,
    input  wire logic [lprq_pkg::BYTE_W-1:0] data_in,
    output lprq_pkg::cmd_t                  cmd,
    output logic                            cmd_valid,
    input  wire logic                       cmd_pop
);
    import lprq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    op_t        op_dec;

    always_comb
    begin
        unique case (kind)
            2'd0:    op_dec = OP_OPEN;
            2'd1:    op_dec = OP_DATA;
            2'd2:    op_dec = OP_POP;
            default: op_dec = OP_NONE;
        endcase
    end

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (cmd_pop && cmd_valid) ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop && cmd_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, len: record_length, din: data_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("command queue overfilled");
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg != 2'd2)) else $error("queue jumped");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[sv/lprq_back.sv]
// Back end: executes queued commands against the byte ring memory, keeps
// the working and committed pointers and issues one result per item.
// Depends on lprq_pkg.
`default_nettype none

module lprq_back #(
    parameter int QUEUE_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lprq_pkg::cmd_t              cmd,
    input  wire logic                        cmd_valid,
    output logic                             cmd_pop,
    output logic                             done,
    output logic [2:0]                       status,
    output logic [lprq_pkg::BYTE_W-1:0]      data_out,
    output logic                             record_last,
    output logic                             queue_empty,
    output logic [lprq_pkg::FREE_W-1:0]      free_bytes,
    output logic [lprq_pkg::CNT_W-1:0]       record_count
);
    import lprq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_BYTES);
    localparam int SUM_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
    localparam int FW    = ((PTR_W + 1) > FREE_W) ? (PTR_W + 1) : FREE_W;
    localparam logic [PTR_W:0]   QW  = (PTR_W + 1)'(QUEUE_BYTES);
    localparam logic [PTR_W:0]   HW  = (PTR_W + 1)'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] QS  = SUM_W'(QUEUE_BYTES);
    localparam logic [SUM_W-1:0] HS  = SUM_W'(HEADER_BYTES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR1 = 5'b00010,
        S_RDH0 = 5'b00100,
        S_RDH1 = 5'b01000,
        S_RDD  = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] add_wrap(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + k;
        if (s >= QW)
            s = s - QW;
        return s[PTR_W-1:0];
    endfunction

    logic [BYTE_W-1:0] mem [QUEUE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  wa, ra;
    logic [BYTE_W-1:0] wd;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wc_reg, wc_next, ww_reg, ww_next;
    logic [PTR_W-1:0]  rc_reg, rc_next, rw_reg, rw_next;
    logic [LEN_W-1:0]  push_left_reg, push_left_next, pop_left_reg, pop_left_next;
    logic              push_open_reg, push_open_next, pop_open_reg, pop_open_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] hdr_lo_reg, hdr_lo_next;
    logic              done_reg, done_next, last_reg, last_next;
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] dout_reg, dout_next;

    logic [SUM_W-1:0]  need;
    logic              refuse;
    logic [LEN_W-1:0]  hdr_len;
    logic [BYTE_W-1:0] hdr_hi;
    logic [PTR_W:0]    free_n;
    logic [FW-1:0]     free_wide;

    always_comb
    begin
        need = SUM_W'(wc_reg) + HS + SUM_W'(cmd.len);
        if (wc_reg < rc_reg)
            refuse = need >= SUM_W'(rc_reg);
        else if (wc_reg > rc_reg)
            refuse = need >= SUM_W'(rc_reg) + QS;
        else
            refuse = HS + SUM_W'(cmd.len) >= QS;
    end

    // only the low twelve bits of the header carry length
    assign hdr_hi  = (HEADER_BYTES > 1) ? rd_data_reg : '0;
    assign hdr_len = {hdr_hi[3:0], hdr_lo_reg};

    always_comb
    begin
        state_next     = state_reg;
        wc_next        = wc_reg;
        ww_next        = ww_reg;
        rc_next        = rc_reg;
        rw_next        = rw_reg;
        push_left_next = push_left_reg;
        pop_left_next  = pop_left_reg;
        push_open_next = push_open_reg;
        pop_open_next  = pop_open_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        hdr_lo_next    = hdr_lo_reg;
        done_next      = 1'b0;
        last_next      = 1'b0;
        status_next    = ST_OK;
        dout_next      = '0;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wa             = wc_reg;
        wd             = cmd.len[7:0];
        ra             = rc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    len_next = cmd.len;
                    unique case (cmd.op)
                        OP_OPEN:
                        begin
                            if (push_open_reg)
                            begin
                                status_next = ST_PUSHOPEN;
                                done_next   = 1'b1;
                            end
                            else if (refuse)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                state_next = S_HDR1;
                            end
                        end
                        OP_DATA:
                        begin
                            done_next = 1'b1;
                            if (!push_open_reg)
                                status_next = ST_NOPUSH;
                            else
                            begin
                                mem_we         = 1'b1;
                                wa             = ww_reg;
                                wd             = cmd.din;
                                ww_next        = add_wrap(ww_reg, (PTR_W + 1)'(1));
                                push_left_next = push_left_reg - 1'b1;
                                if (push_left_reg == LEN_W'(1))
                                begin
                                    wc_next        = ww_next;
                                    count_next     = count_reg + 1'b1;
                                    push_open_next = 1'b0;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (pop_open_reg)
                            begin
                                mem_re     = 1'b1;
                                ra         = rw_reg;
                                state_next = S_RDD;
                            end
                            else if (rc_reg == wc_reg)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDH0;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_HDR1:
            begin
                if (HEADER_BYTES > 1)
                begin
                    mem_we = 1'b1;
                    wa     = add_wrap(wc_reg, (PTR_W + 1)'(1));
                    wd     = {4'd0, len_reg[11:8]};
                end
                ww_next        = add_wrap(wc_reg, HW);
                push_left_next = len_reg;
                push_open_next = (len_reg != '0);
                if (len_reg == '0)
                begin
                    wc_next    = ww_next;
                    count_next = count_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RDH0:
            begin
                hdr_lo_next = rd_data_reg;
                mem_re      = (HEADER_BYTES > 1);
                ra          = add_wrap(rc_reg, (PTR_W + 1)'(1));
                state_next  = S_RDH1;
            end
            S_RDH1:
            begin
                rw_next = add_wrap(rc_reg, HW);
                if (hdr_len == '0)
                begin
                    // empty record finishes on its opening request
                    rc_next    = rw_next;
                    count_next = count_reg - 1'b1;
                    last_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pop_open_next = 1'b1;
                    pop_left_next = hdr_len;
                    mem_re        = 1'b1;
                    ra            = rw_next;
                    state_next    = S_RDD;
                end
            end
            S_RDD:
            begin
                dout_next     = rd_data_reg;
                rw_next       = add_wrap(rw_reg, (PTR_W + 1)'(1));
                pop_left_next = pop_left_reg - 1'b1;
                if (pop_left_reg == LEN_W'(1))
                begin
                    rc_next       = rw_next;
                    count_next    = count_reg - 1'b1;
                    pop_open_next = 1'b0;
                    last_next     = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wa] <= wd;
        if (mem_re)
            rd_data_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wc_reg        <= '0;
            ww_reg        <= '0;
            rc_reg        <= '0;
            rw_reg        <= '0;
            push_left_reg <= '0;
            pop_left_reg  <= '0;
            push_open_reg <= 1'b0;
            pop_open_reg  <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            ww_reg        <= ww_next;
            rc_reg        <= rc_next;
            rw_reg        <= rw_next;
            push_left_reg <= push_left_next;
            pop_left_reg  <= pop_left_next;
            push_open_reg <= push_open_next;
            pop_open_reg  <= pop_open_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        hdr_lo_reg <= hdr_lo_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

    always_comb
    begin
        if (wc_reg < rc_reg)
            free_n = {1'b0, rc_reg} - {1'b0, wc_reg};
        else if (wc_reg > rc_reg)
            free_n = QW - {1'b0, wc_reg} + {1'b0, rc_reg};
        else
            free_n = QW;
        free_wide = FW'(free_n);
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign data_out     = dout_reg;
    assign record_last  = last_reg;
    assign queue_empty  = (rc_reg == wc_reg);
    assign free_bytes   = free_wide[FREE_W-1:0];
    assign record_count = count_reg;

    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (status_reg == ST_OK))
        else $error("record end flagged on a failed item");
    a_wc_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wc_reg) |-> done_reg) else $error("write commit without result");
    a_rc_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rc_reg) |-> (done_reg && last_reg))
        else $error("read commit without last byte");
    a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg) else $error("count moved without result");

endmodule

`default_nettype wire

[sv/length_prefixed_record_ring_queue.sv]
// Length-prefixed record ring queue: variable-length records in a byte ring.
// Each item waits in the two-entry front queue, which buffers start, until the
// back end takes it; the back end works on one item at a time. A data byte or
// refused item is handled in S_IDLE, a push open in S_IDLE and S_HDR1, and a pop
// opening a record in S_RDH0, S_RDH1 (where an empty record ends) and S_RDD.
// Reset (rst_n, async) empties the queue; ring contents are not cleared.
`default_nettype none

module length_prefixed_record_ring_queue #(
    parameter int QUEUE_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [lprq_pkg::LEN_W-1:0]  record_length,
    input  wire logic [lprq_pkg::BYTE_W-1:0] data_in,
    output logic                             done,
    output logic [2:0]                       status,
    output logic [lprq_pkg::BYTE_W-1:0]      data_out,
    output logic                             record_last,
    output logic                             queue_empty,
    output logic [lprq_pkg::FREE_W-1:0]      free_bytes,
    output logic [lprq_pkg::CNT_W-1:0]       record_count
);
    import lprq_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    lprq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .record_length (record_length),
        .data_in       (data_in),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    lprq_back #(
        .QUEUE_BYTES  (QUEUE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .done         (done),
        .status       (status),
        .data_out     (data_out),
        .record_last  (record_last),
        .queue_empty  (queue_empty),
        .free_bytes   (free_bytes),
        .record_count (record_count)
    );

endmodule

`default_nettype wire
